/* rtl/tipg_pkg.sv */
package tipg_pkg;

  localparam int DEF_IMAGE_SIDE = 64;

  // byte offset: 12 bits, 32 bytes per 8x4 block
  localparam int IDX_W   = 12;
  localparam int LOCAL_W = 5;
  localparam int BLK_W   = IDX_W - LOCAL_W;
  localparam int PIX_W   = 6;
  localparam int LVL_W   = 6;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE   = 3'd0,
    SHAPE_RING_OUT = 3'd1,
    SHAPE_RINGS    = 3'd2,
    SHAPE_OCTAGRAM = 3'd3,
    SHAPE_CIRC_TRI = 3'd4
  } shape_t;

  localparam logic [LVL_W-1:0] LVL_OFF  = 6'h00;
  localparam logic [LVL_W-1:0] LVL_LOW  = 6'h11;
  localparam logic [LVL_W-1:0] LVL_MID  = 6'h22;
  localparam logic [LVL_W-1:0] LVL_HIGH = 6'h33;

  function automatic logic [LVL_W-1:0] ring_level(input logic [2:0] k);
    logic [LVL_W-1:0] lvl;
    case (k)
      3'd0:    lvl = LVL_LOW;
      3'd1:    lvl = LVL_MID;
      3'd2:    lvl = LVL_LOW;
      3'd3:    lvl = LVL_LOW;
      default: lvl = LVL_MID;
    endcase
    return lvl;
  endfunction

endpackage

/* rtl/tiled_icon_pixel_generator_core.sv */
// channel  ports                                                 handshake
// input    start, busy, in_byte_index                            start & !busy
// result   out_valid, out_pixel_x, out_pixel_y, out_intensity    out_valid strobe, one cycle
// config   cfg_wr_en, cfg_wr_data                                cfg_wr_en
//
// four-stage pipeline: input register, unswizzle (reciprocal multiply),
// offsets and squares, threshold compares into the result register.
// one item per cycle; its result strobes once it has passed the unswizzle, squares and result registers.
// busy is always low. synchronous reset clears the valid pipe and the
// shape register (filled circle). the receiver cannot stall.
module tiled_icon_pixel_generator_core import tipg_pkg::*; #(
  parameter int IMAGE_SIDE = DEF_IMAGE_SIDE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [IDX_W-1:0] in_byte_index,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel_x,
  output logic [PIX_W-1:0] out_pixel_y,
  output logic [LVL_W-1:0] out_intensity
);

  localparam int Across = IMAGE_SIDE / 8;
  localparam int BlkMax = 2 ** BLK_W - 1;
  localparam int YMax   = (BlkMax / Across) * 4 + 3;
  localparam int XW     = $clog2(8 * Across);
  localparam int YW     = $clog2(YMax + 1);

  shape_t shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_CIRCLE;
    end else if (cfg_wr_en) begin
      shape_r <= shape_t'(cfg_wr_data);
    end
  end

  assign busy = 1'b0;

  logic             v1_r, v2_r, v3_r, out_valid_r;
  logic [IDX_W-1:0] idx1_r;
  logic [XW-1:0]    x2_r, x3_r, x2_nxt;
  logic [YW-1:0]    y2_r, y3_r, y2_nxt;
  logic [PIX_W-1:0] px_r, py_r;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;

  tipg_xy #(.IMAGE_SIDE(IMAGE_SIDE), .XW(XW), .YW(YW)) u_xy (
    .idx (idx1_r),
    .x   (x2_nxt),
    .y   (y2_nxt)
  );

  tipg_shade #(.IMAGE_SIDE(IMAGE_SIDE), .XW(XW), .YW(YW)) u_shade (
    .clk       (clk),
    .x         (x2_r),
    .y         (y2_r),
    .shape     (shape_r),
    .intensity (lvl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // payload pipe, no reset needed
  always_ff @(posedge clk) begin
    idx1_r <= in_byte_index;
    x2_r   <= x2_nxt;
    y2_r   <= y2_nxt;
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    px_r   <= PIX_W'(x3_r);
    py_r   <= PIX_W'(y3_r);
    lvl_r  <= lvl_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_x   = px_r;
  assign out_pixel_y   = py_r;
  assign out_intensity = lvl_r;

endmodule

/* rtl/tipg_xy.sv */
module tipg_xy import tipg_pkg::*; #(
  parameter int IMAGE_SIDE = DEF_IMAGE_SIDE,
  parameter int XW = 6,
  parameter int YW = 6
) (
  input  logic [IDX_W-1:0] idx,
  output logic [XW-1:0]    x,
  output logic [YW-1:0]    y
);

  localparam int Across     = IMAGE_SIDE / 8;
  localparam int RecipShift = 14;
  localparam int Recip      = (2 ** RecipShift + Across - 1) / Across;
  localparam int PW         = BLK_W + RecipShift + 1;

  logic [BLK_W-1:0] blk;
  logic [PW-1:0]    prod;
  logic [BLK_W-1:0] by;
  logic [BLK_W-1:0] bx;

  // block row by reciprocal multiply, exact for all 7-bit block numbers
  assign blk  = idx[IDX_W-1:LOCAL_W];
  assign prod = PW'(blk) * PW'(Recip);
  assign by   = prod[RecipShift +: BLK_W];
  assign bx   = blk - BLK_W'(by * BLK_W'(Across));

  assign x = XW'({bx, idx[2:0]});
  assign y = YW'({by, idx[LOCAL_W-1:3]});

endmodule

/* rtl/tipg_shade.sv */
module tipg_shade import tipg_pkg::*; #(
  parameter int IMAGE_SIDE = DEF_IMAGE_SIDE,
  parameter int XW = 6,
  parameter int YW = 6
) (
  input  logic             clk,
  input  logic [XW-1:0]    x,
  input  logic [YW-1:0]    y,
  input  shape_t           shape,
  output logic [LVL_W-1:0] intensity
);

  localparam int MW  = ($clog2(IMAGE_SIDE) + 1 > YW + 2) ? $clog2(IMAGE_SIDE) + 1 : YW + 2;
  localparam int CW  = MW + 1;
  localparam int RW  = MW + 4;
  localparam int RSW = RW + 1;
  localparam int SQ  = 2 * MW;
  localparam int RSQ = 2 * RW;
  localparam int EW  = 2 * RW + 2;

  localparam logic [EW-1:0] SideE = EW'(IMAGE_SIDE);
  localparam logic [EW-1:0] S2    = EW'(IMAGE_SIDE * IMAGE_SIDE);

  // first half: doubled centre offsets and squares
  logic signed [CW-1:0]  u, v;
  logic [MW-1:0]         a, b;
  logic signed [RSW-1:0] r;
  logic [RW-1:0]         rmag;
  logic                  rpos, tri_v;

  assign u    = $signed(CW'({x, 1'b1})) - $signed(CW'(IMAGE_SIDE));
  assign v    = $signed(CW'({y, 1'b1})) - $signed(CW'(IMAGE_SIDE));
  assign a    = u[CW-1] ? MW'(-u) : MW'(u);
  assign b    = v[CW-1] ? MW'(-v) : MW'(v);
  assign r    = RSW'(5 * IMAGE_SIDE) + RSW'(6) * RSW'(v);
  assign rpos = !r[RSW-1] && (r != '0);
  assign rmag = RW'(r);
  assign tri_v = (RSW'(12) * RSW'(v)) < RSW'(5 * IMAGE_SIDE);

  logic [MW-1:0]  a_r, b_r;
  logic [SQ-1:0]  aa_r, bb_r;
  logic [RSQ-1:0] rr_r;
  logic           rpos_r, tri_v_r;

  always_ff @(posedge clk) begin
    a_r     <= a;
    b_r     <= b;
    aa_r    <= SQ'(a) * SQ'(a);
    bb_r    <= SQ'(b) * SQ'(b);
    rr_r    <= RSQ'(rmag) * RSQ'(rmag);
    rpos_r  <= rpos;
    tri_v_r <= tri_v;
  end

  // second half: threshold compares and level select
  logic [EW-1:0]    d, d36, mm, ab;
  logic             in_c, in_tri, oct_off, oct_mid;
  logic [2:0]       k;

  assign d   = EW'(aa_r) + EW'(bb_r);
  assign d36 = d * EW'(36);
  assign mm  = (aa_r > bb_r) ? EW'(aa_r) : EW'(bb_r);
  assign ab  = EW'(a_r) + EW'(b_r);

  assign in_c    = d < S2;
  assign oct_off = (ab > SideE) && ((mm << 1) > S2);
  assign oct_mid = (EW'(3) * ab > (SideE << 1)) && (EW'(9) * mm > (S2 << 1));
  assign in_tri  = tri_v_r && rpos_r && (EW'(108) * EW'(aa_r) < EW'(rr_r));

  // ring number: thresholds rise with j, so count the ones passed
  always_comb begin
    k = 3'd0;
    for (int j = 1; j <= 5; j++) begin
      if (EW'(j * j) * S2 <= d36) k = 3'(j);
    end
  end

  always_comb begin
    case (shape)
      SHAPE_CIRCLE:   intensity = in_c ? LVL_LOW : LVL_OFF;
      SHAPE_RING_OUT: begin
        if (!in_c) intensity = LVL_OFF;
        else if ((d << 4) < EW'(9) * S2) intensity = LVL_MID;
        else intensity = LVL_LOW;
      end
      SHAPE_RINGS:    intensity = in_c ? ring_level(k) : LVL_OFF;
      SHAPE_OCTAGRAM: begin
        if (oct_off) intensity = LVL_OFF;
        else if (oct_mid) intensity = LVL_MID;
        else intensity = LVL_HIGH;
      end
      SHAPE_CIRC_TRI: begin
        if (in_tri) intensity = LVL_MID;
        else if (!in_c) intensity = LVL_OFF;
        else if (d36 < EW'(25) * S2) intensity = LVL_HIGH;
        else intensity = LVL_MID;
      end
      default:        intensity = LVL_OFF;
    endcase
  end

endmodule

/* verif/tiled_icon_pixel_generator_core_tb.sv */
`timescale 1ns / 100ps

module tiled_icon_pixel_generator_core_tb;
  import tipg_pkg::*;

  localparam int SIDE        = DEF_IMAGE_SIDE;
  localparam int STALL_LIMIT = 1000;

  // codes the shape register accepts but does not paint with
  localparam logic [2:0] SHAPE_SPARE_LO  = 3'd5;
  localparam logic [2:0] SHAPE_SPARE_MID = 3'd6;
  localparam logic [2:0] SHAPE_SPARE_HI  = 3'd7;

  localparam logic [LVL_W-1:0] RING_LVL [6] = '{LVL_LOW, LVL_MID, LVL_LOW,
                                                LVL_LOW, LVL_MID, LVL_MID};

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [LVL_W-1:0] lvl;
  } pixel_t;

  typedef struct packed {
    logic             wr;
    logic [2:0]       shape;
    logic [IDX_W-1:0] idx;
    logic             typed;
    pixel_t           px;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [IDX_W-1:0] in_byte_index = '0;
  logic             cfg_wr_en = 1'b0;
  logic [2:0]       cfg_wr_data = '0;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel_x;
  logic [PIX_W-1:0] out_pixel_y;
  logic [LVL_W-1:0] out_intensity;

  pixel_t     pending_px[$];
  logic [2:0] shape_now = SHAPE_CIRCLE;
  int         mismatch_count = 0;
  int         stall_cycles = 0;

  // center pixel (32,32) sits at offset 2176, corners at 0 and 4095
  dir_row_t dir_rows [0:18] = '{
    '{1'b0, SHAPE_CIRCLE,    12'd0,    1'b1, '{6'd0,  6'd0,  LVL_OFF}},
    '{1'b0, SHAPE_CIRCLE,    12'd4095, 1'b1, '{6'd63, 6'd63, LVL_OFF}},
    '{1'b0, SHAPE_CIRCLE,    12'd2176, 1'b1, '{6'd32, 6'd32, LVL_LOW}},
    '{1'b0, SHAPE_CIRCLE,    12'hAAA,  1'b0, '0},
    '{1'b0, SHAPE_CIRCLE,    12'h555,  1'b0, '0},
    '{1'b1, SHAPE_RING_OUT,  12'd2176, 1'b1, '{6'd32, 6'd32, LVL_MID}},
    '{1'b0, SHAPE_RING_OUT,  12'd1100, 1'b0, '0},
    '{1'b1, SHAPE_RINGS,     12'd2176, 1'b1, '{6'd32, 6'd32, LVL_LOW}},
    '{1'b0, SHAPE_RINGS,     12'd2180, 1'b0, '0},
    '{1'b0, SHAPE_RINGS,     12'd2213, 1'b0, '0},
    '{1'b1, SHAPE_OCTAGRAM,  12'd2176, 1'b1, '{6'd32, 6'd32, LVL_HIGH}},
    '{1'b0, SHAPE_OCTAGRAM,  12'd0,    1'b1, '{6'd0,  6'd0,  LVL_OFF}},
    '{1'b0, SHAPE_OCTAGRAM,  12'd1600, 1'b0, '0},
    '{1'b1, SHAPE_CIRC_TRI,  12'd2176, 1'b1, '{6'd32, 6'd32, LVL_MID}},
    '{1'b0, SHAPE_CIRC_TRI,  12'd0,    1'b1, '{6'd0,  6'd0,  LVL_OFF}},
    '{1'b0, SHAPE_CIRC_TRI,  12'd3000, 1'b0, '0},
    '{1'b1, SHAPE_SPARE_LO,  12'd2176, 1'b1, '{6'd32, 6'd32, LVL_OFF}},
    '{1'b1, SHAPE_SPARE_HI,  12'd4095, 1'b1, '{6'd63, 6'd63, LVL_OFF}},
    '{1'b1, SHAPE_SPARE_MID, 12'd2176, 1'b1, '{6'd32, 6'd32, LVL_OFF}}
  };

  tiled_icon_pixel_generator_core #(
    .IMAGE_SIDE(SIDE)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_byte_index(in_byte_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_intensity(out_intensity)
  );

  always #6 clk = ~clk;

  // unswizzle the 8x4 block tiling, then paint from doubled center offsets
  function automatic pixel_t predict_pixel(input logic [IDX_W-1:0] idx,
                                           input logic [2:0] shape);
    longint     across, blk, col, row, s, s2, u, v, d, a, b, m, r;
    logic [2:0] k;
    bit         in_tri;
    pixel_t     px;
    across = longint'(SIDE >> 3);
    if (across == 0) across = 1;
    blk = longint'(idx[IDX_W-1:LOCAL_W]);
    col = (blk % across) * 8 + longint'(idx[2:0]);
    row = (blk / across) * 4 + longint'(idx[4:3]);
    s   = longint'(SIDE);
    s2  = s * s;
    u   = 2 * col + 1 - s;
    v   = 2 * row + 1 - s;
    d   = u * u + v * v;
    a   = (u < 0) ? -u : u;
    b   = (v < 0) ? -v : v;
    m   = (a > b) ? a : b;
    px.x   = col[PIX_W-1:0];
    px.y   = row[PIX_W-1:0];
    px.lvl = LVL_OFF;
    case (shape)
      SHAPE_CIRCLE: begin
        if (d < s2) px.lvl = LVL_LOW;
      end
      SHAPE_RING_OUT: begin
        if (d < s2) px.lvl = (16 * d < 9 * s2) ? LVL_MID : LVL_LOW;
      end
      SHAPE_RINGS: begin
        if (d < s2) begin
          k = 3'd0;
          for (int j = 1; j <= 5; j++)
            if (j * j * s2 <= 36 * d) k = 3'(j);
          px.lvl = RING_LVL[k];
        end
      end
      SHAPE_OCTAGRAM: begin
        if (a + b > s && 2 * m * m > s2) px.lvl = LVL_OFF;
        else if (3 * (a + b) > 2 * s && 9 * m * m > 2 * s2) px.lvl = LVL_MID;
        else px.lvl = LVL_HIGH;
      end
      SHAPE_CIRC_TRI: begin
        // triangle edge 6*sqrt3*|u| < 5S+6v, squared on both sides
        r = 5 * s + 6 * v;
        in_tri = (12 * v < 5 * s) && (r > 0) && (108 * a * a < r * r);
        if (in_tri) px.lvl = LVL_MID;
        else if (d < s2) px.lvl = (36 * d < 25 * s2) ? LVL_HIGH : LVL_MID;
      end
      default: px.lvl = LVL_OFF;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_pixel(input logic [IDX_W-1:0] idx, input bit typed,
                            input pixel_t typed_px);
    pixel_t want;
    start         <= 1'b1;
    in_byte_index <= idx;
    do @(posedge clk); while (busy);
    want = typed ? typed_px : predict_pixel(idx, shape_now);
    pending_px.push_back(want);
  endtask

  // register writes only once the pipe has drained
  task automatic apply_shape(input logic [2:0] shape);
    start <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= shape;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shape_now = shape;
  endtask

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_px.size() == 0) begin
        report_mismatch("result with no item pending, intensity", int'(out_intensity), -1);
      end else begin
        want = pending_px.pop_front();
        if (out_pixel_x !== want.x)
          report_mismatch("pixel_x", int'(out_pixel_x), int'(want.x));
        if (out_pixel_y !== want.y)
          report_mismatch("pixel_y", int'(out_pixel_y), int'(want.y));
        if (out_intensity !== want.lvl)
          report_mismatch("intensity", int'(out_intensity), int'(want.lvl));
      end
    end
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [IDX_W-1:0] idx;
    logic [2:0]       shape;
    int               run_left;
    int               pick;
    bit               no_gaps;
    idx      = '0;
    run_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: the first ones run on the reset shape
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) apply_shape(dir_rows[i].shape);
      send_pixel(dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].px);
    end

    for (int p = 0; p < 12; p++) begin
      if (p < 8) shape = 3'(p);
      else if ($urandom_range(0, 9) < 8)
        shape = 3'($urandom_range(SHAPE_CIRCLE, SHAPE_CIRC_TRI));
      else shape = 3'($urandom_range(SHAPE_SPARE_LO, SHAPE_SPARE_HI));
      apply_shape(shape);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 100; n++) begin
        // runs of consecutive offsets mimic a texture fill
        if (run_left > 0) begin
          idx = idx + 1'b1;
          run_left--;
        end else if ($urandom_range(0, 9) < 3) begin
          idx      = IDX_W'($urandom_range(0, 4095));
          run_left = $urandom_range(4, 40);
        end else begin
          idx = IDX_W'($urandom_range(0, 4095));
        end
        send_pixel(idx, 1'b0, '0);
        pick = $urandom_range(0, 99);
        if (!no_gaps && pick >= 70) begin
          start <= 1'b0;
          if (pick < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(8, 40)) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* tiled_icon_pixel_generator_core.f */
rtl/tipg_pkg.sv
rtl/tipg_xy.sv
rtl/tipg_shade.sv
rtl/tiled_icon_pixel_generator_core.sv
verif/tiled_icon_pixel_generator_core_tb.sv
